### rtl/smc_pkg.sv
`timescale 1ns / 1ps
// shared constants, register indexes and byte helpers for the substring match counter
// no dependencies

package smc_pkg;

	// default and limit of the pattern length
	localparam int MAX_PATTERN_DEF = 32;
	localparam int PAT_WORD_W      = 64;
	localparam int PAT_WORDS       = 4;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;
	localparam int LEN_CFG_W  = 6;
	localparam int MODE_W     = 2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PAT_WORD_0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PAT_WORD_1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PAT_WORD_2 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PAT_WORD_3 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MODE       = 3'd5;

	// search modes; the unused code behaves as whole word
	localparam logic [MODE_W-1:0] MODE_EXACT = 2'd0;
	localparam logic [MODE_W-1:0] MODE_FOLD  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_WORD  = 2'd2;

	// result field widths
	localparam int LINE_NUM_W   = 32;
	localparam int LINE_MATCH_W = 16;
	localparam int FILE_TOTAL_W = 32;
	localparam int OUT_DATA_W   = LINE_NUM_W + LINE_MATCH_W + FILE_TOTAL_W;

	// ascii upper case to lower case, everything else unchanged
	function automatic logic [7:0] fold_byte(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= 8'h41 && c <= 8'h5A) begin
			r = c + 8'd32;
		end
		return r;
	endfunction

	// anything other than an ascii letter or digit separates words
	function automatic logic is_boundary(input logic [7:0] c);
		logic alnum;
		alnum = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
			(c >= 8'h30 && c <= 8'h39);
		return !alnum;
	endfunction

endpackage

### rtl/smc_match.sv
`timescale 1ns / 1ps
// parallel compare of the newest window bytes against the pattern
// depends on smc_pkg

module smc_match #(
	parameter int MAX_PATTERN = smc_pkg::MAX_PATTERN_DEF,
	parameter int LEN_W       = $clog2(MAX_PATTERN + 1)
) (
	input  logic [7:0]               window [MAX_PATTERN],
	input  logic [MAX_PATTERN*8-1:0] pattern,
	input  logic [LEN_W-1:0]         len,
	input  logic                     folded,
	output logic                     hit
);
	import smc_pkg::*;

	logic [MAX_PATTERN*8-1:0] rev;
	logic [MAX_PATTERN*8-1:0] aligned;
	logic [LEN_W-1:0]         shift;
	logic [MAX_PATTERN-1:0]   eq;

	// window reversed so oldest of the used bytes lands at byte 0 after the shift
	always_comb begin
		for (int j = 0; j < MAX_PATTERN; j++) begin
			rev[j*8 +: 8] = folded ? fold_byte(window[MAX_PATTERN-1-j])
				: window[MAX_PATTERN-1-j];
		end
	end

	assign shift   = LEN_W'(MAX_PATTERN) - len;
	assign aligned = rev >> {shift, 3'b000};

	// per byte compare, bytes beyond the length always agree
	always_comb begin
		for (int i = 0; i < MAX_PATTERN; i++) begin
			eq[i] = (LEN_W'(i) >= len) ||
				(aligned[i*8 +: 8] ==
				(folded ? fold_byte(pattern[i*8 +: 8]) : pattern[i*8 +: 8]));
		end
	end

	assign hit = &eq;

endmodule

### rtl/substring_match_counter_top.sv
`timescale 1ns / 1ps
// Substring match counter: one text byte per cycle while no report blocks it, one report word per finished line.
// Report path: an accepted line-end byte is registered in the input stage, then its report in the m_tdata register.
// Throughput: one byte per cycle, set by the single window compare between the input
// stage and the line state registers; a waiting report holds up the input only once the
// next line-end byte has reached the input stage.
// Reset: counters, flags and configuration return to their reset values at once;
// the byte window is left as it is, since only bytes of the current line are read.
// depends on smc_pkg and smc_match

module substring_match_counter_top #(
	parameter int MAX_PATTERN = smc_pkg::MAX_PATTERN_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// input stream
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,  // text_byte [7:0]
	input  logic                          s_tlast,  // line_end
	input  logic                          s_tuser,  // file_start
	// report stream
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [smc_pkg::OUT_DATA_W-1:0] m_tdata, // line_number [31:0],
	                                                // line_matches [47:32],
	                                                // file_total [79:48]
	output logic                          m_tuser,  // line_has_match
	// configuration
	input  logic                          cfg_we,
	input  logic [smc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [smc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import smc_pkg::*;

	localparam int WIN_DEPTH = MAX_PATTERN + 1;
	localparam int LEN_W     = $clog2(MAX_PATTERN + 1);
	localparam int CNT_W     = $clog2(WIN_DEPTH + 1);

	// configuration registers
	logic [PAT_WORD_W-1:0] pat_q [PAT_WORDS];
	logic [LEN_CFG_W-1:0]  len_q;
	logic [MODE_W-1:0]     mode_q;

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       start_s1;

	// line and file state
	logic [7:0]              win_q [WIN_DEPTH];
	logic [CNT_W-1:0]        cnt_q;
	logic                    pend_q;
	logic [LINE_NUM_W-1:0]   line_q;
	logic [LINE_MATCH_W-1:0] lmc_q;
	logic [FILE_TOTAL_W-1:0] total_q;

	// report register
	logic                    out_valid_q;
	logic [LINE_NUM_W-1:0]   out_line_q;
	logic [LINE_MATCH_W-1:0] out_lmc_q;
	logic [FILE_TOTAL_W-1:0] out_total_q;
	logic                    out_has_q;

	logic                    adv;
	logic                    s_acc;
	logic [7:0]              win_new [WIN_DEPTH];
	logic [7:0]              cmp_win [MAX_PATTERN];
	logic [PAT_WORDS*PAT_WORD_W-1:0] pat_flat;
	logic [LEN_W-1:0]        len_eff;
	logic                    folded;
	logic                    whole;
	logic [CNT_W-1:0]        cnt_base;
	logic [CNT_W-1:0]        cnt_new;
	logic                    pend_base;
	logic [LINE_NUM_W-1:0]   line_base;
	logic [LINE_MATCH_W-1:0] lmc_base;
	logic [FILE_TOTAL_W-1:0] tot_base;
	logic                    hit;
	logic                    hit_ok;
	logic                    before_ok;
	logic                    pend_hit;
	logic                    new_hit;
	logic                    set_pend;
	logic [1:0]              inc;
	logic [LINE_MATCH_W:0]   lmc_sum;
	logic [FILE_TOTAL_W:0]   tot_sum;
	logic [LINE_MATCH_W-1:0] lmc_next;
	logic [FILE_TOTAL_W-1:0] tot_next;
	logic [LINE_NUM_W-1:0]   line_inc;

	// handshake: the stage moves on unless it holds a line-end byte while a report is blocked
	assign adv      = valid_s1 && (!last_s1 || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;
	assign s_acc    = s_tvalid && s_tready;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < PAT_WORDS; k++) begin
				pat_q[k] <= '0;
			end
			len_q  <= LEN_CFG_W'(1);
			mode_q <= MODE_EXACT;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PAT_WORD_0: pat_q[0] <= cfg_data;
				REG_PAT_WORD_1: pat_q[1] <= cfg_data;
				REG_PAT_WORD_2: pat_q[2] <= cfg_data;
				REG_PAT_WORD_3: pat_q[3] <= cfg_data;
				REG_PAT_LEN:    len_q    <= cfg_data[LEN_CFG_W-1:0];
				REG_MODE:       mode_q   <= cfg_data[MODE_W-1:0];
				default: ;
			endcase
		end
	end

	// effective length and mode
	always_comb begin
		if (len_q == '0) begin
			len_eff = LEN_W'(1);
		end else if (len_q > LEN_CFG_W'(MAX_PATTERN)) begin
			len_eff = LEN_W'(MAX_PATTERN);
		end else begin
			len_eff = len_q[LEN_W-1:0];
		end
	end
	assign folded   = (mode_q != MODE_EXACT);
	assign whole    = (mode_q >= MODE_WORD);
	assign pat_flat = {pat_q[3], pat_q[2], pat_q[1], pat_q[0]};

	// input stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_acc) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	// input stage payload
	always_ff @(posedge clk) begin
		if (s_acc) begin
			byte_s1  <= s_tdata;
			last_s1  <= s_tlast;
			start_s1 <= s_tuser;
		end
	end

	// state as seen after an optional file restart
	assign cnt_base  = start_s1 ? '0 : cnt_q;
	assign pend_base = !start_s1 && pend_q;
	assign line_base = start_s1 ? LINE_NUM_W'(1) : line_q;
	assign lmc_base  = start_s1 ? '0 : lmc_q;
	assign tot_base  = start_s1 ? '0 : total_q;
	assign cnt_new   = (cnt_base == CNT_W'(WIN_DEPTH)) ? cnt_base : cnt_base + CNT_W'(1);

	// shifted window, newest byte first
	always_comb begin
		win_new[0] = byte_s1;
		for (int i = 1; i < WIN_DEPTH; i++) begin
			win_new[i] = win_q[i-1];
		end
		for (int i = 0; i < MAX_PATTERN; i++) begin
			cmp_win[i] = win_new[i];
		end
	end

	smc_match #(
		.MAX_PATTERN (MAX_PATTERN),
		.LEN_W       (LEN_W)
	) u_match (
		.window  (cmp_win),
		.pattern (pat_flat[MAX_PATTERN*8-1:0]),
		.len     (len_eff),
		.folded  (folded),
		.hit     (hit)
	);

	// match decisions, pending word match and saturating counts
	assign hit_ok    = hit && (cnt_new >= CNT_W'(len_eff));
	assign before_ok = (cnt_new == CNT_W'(len_eff)) || is_boundary(win_new[len_eff]);
	assign pend_hit  = pend_base && is_boundary(byte_s1);
	assign new_hit   = hit_ok && (!whole || (before_ok && last_s1));
	assign set_pend  = hit_ok && whole && before_ok && !last_s1;
	assign inc       = {1'b0, pend_hit} + {1'b0, new_hit};
	assign lmc_sum   = {1'b0, lmc_base} + (LINE_MATCH_W+1)'(inc);
	assign tot_sum   = {1'b0, tot_base} + (FILE_TOTAL_W+1)'(inc);
	assign lmc_next  = lmc_sum[LINE_MATCH_W] ? '1 : lmc_sum[LINE_MATCH_W-1:0];
	assign tot_next  = tot_sum[FILE_TOTAL_W] ? '1 : tot_sum[FILE_TOTAL_W-1:0];
	assign line_inc  = (line_base == '1) ? line_base : line_base + LINE_NUM_W'(1);

	// byte window
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < WIN_DEPTH; i++) begin
				win_q[i] <= win_new[i];
			end
		end
	end

	// line and file counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			pend_q  <= 1'b0;
			line_q  <= LINE_NUM_W'(1);
			lmc_q   <= '0;
			total_q <= '0;
		end else if (adv) begin
			total_q <= tot_next;
			if (last_s1) begin
				cnt_q  <= '0;
				pend_q <= 1'b0;
				lmc_q  <= '0;
				line_q <= line_inc;
			end else begin
				cnt_q  <= cnt_new;
				pend_q <= set_pend;
				lmc_q  <= lmc_next;
				line_q <= line_base;
			end
		end
	end

	// report valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// report word
	always_ff @(posedge clk) begin
		if (adv && last_s1) begin
			out_line_q  <= line_base;
			out_lmc_q   <= lmc_next;
			out_total_q <= tot_next;
			out_has_q   <= (lmc_next != '0);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_total_q, out_lmc_q, out_line_q};
	assign m_tuser  = out_has_q;

endmodule

### tb/substring_match_counter_top_tb.sv
`timescale 1ns / 1ps
// self-checking bench for substring_match_counter_top: directed table, then random text phases
// every line report is checked against table values or the bench's line match counter
// depends on smc_pkg and the substring_match_counter_top rtl

module substring_match_counter_top_tb;
	import smc_pkg::*;

	localparam int WIN_BYTES       = MAX_PATTERN_DEF + 1;
	localparam int SETTLE          = 6;
	localparam int HOLD_CYCLES     = 300;
	localparam int PHASES          = 8;
	localparam int ITEMS_PER_PHASE = 200;
	localparam int CYCLE_LIMIT     = 400000;
	localparam int PRINT_LIMIT     = 40;

	// mode code not named in the package, behaves as whole word
	localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

	typedef struct packed {
		logic [LINE_NUM_W-1:0]   line_number;
		logic [LINE_MATCH_W-1:0] line_matches;
		logic [FILE_TOTAL_W-1:0] file_total;
		logic                    has_match;
	} line_report_t;

	typedef enum logic {ROW_TEXT, ROW_REG} row_kind_e;

	typedef struct packed {
		row_kind_e              kind;
		logic [CFG_IDX_W-1:0]   reg_idx;
		logic [CFG_DATA_W-1:0]  value;
		logic [7:0]             text;
		logic                   eol;
		logic                   restart;
		logic                   fixed;
		line_report_t           want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [7:0] s_tdata = '0;
	logic s_tlast = 1'b0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic m_tuser;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// bench copy of configuration and line state
	logic [PAT_WORD_W-1:0] pat_words [PAT_WORDS];
	logic [LEN_CFG_W-1:0] pat_len;
	logic [MODE_W-1:0] cur_mode;
	logic [7:0] win_bytes [WIN_BYTES];
	int unsigned seen_in_line;
	bit word_pending;
	logic [LINE_NUM_W-1:0] line_no;
	logic [LINE_MATCH_W-1:0] line_hits;
	logic [FILE_TOTAL_W-1:0] file_hits;

	line_report_t reports_due [$];
	stim_row_t plan [$];

	int errors = 0;
	int reports_seen = 0;
	int cycle_count = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_req = 1'b0;
	int hold_left = 0;

	substring_match_counter_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),  // text_byte [7:0]
		.s_tlast   (s_tlast),  // line_end
		.s_tuser   (s_tuser),  // file_start
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),  // line_number [31:0], line_matches [47:32], file_total [79:48]
		.m_tuser   (m_tuser),  // line_has_match
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// clock
	always #10 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d reports still due", cycle_count,
				reports_due.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	// ---------------------------------------------------------------- byte helpers

	function automatic logic [7:0] lower_byte(input logic [7:0] c);
		if (c >= 8'h41 && c <= 8'h5A) begin
			return c + 8'd32;
		end
		return c;
	endfunction

	function automatic bit is_separator(input logic [7:0] c);
		return !((c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
			(c >= 8'h30 && c <= 8'h39));
	endfunction

	function automatic logic [7:0] pat_byte(input int unsigned k);
		return pat_words[k / 8][(k % 8) * 8 +: 8];
	endfunction

	// zero acts as one, anything beyond the window limit as the limit
	function automatic int unsigned active_len();
		if (pat_len == 0) begin
			return 1;
		end
		if (pat_len > MAX_PATTERN_DEF) begin
			return MAX_PATTERN_DEF;
		end
		return 32'(pat_len);
	endfunction

	// ---------------------------------------------------------------- line match counter

	function automatic void clear_line_state();
		foreach (win_bytes[k]) begin
			win_bytes[k] = '0;
		end
		seen_in_line = 0;
		word_pending = 1'b0;
		line_hits = '0;
	endfunction

	function automatic void bump_counts();
		if (line_hits != '1) begin
			line_hits++;
		end
		if (file_hits != '1) begin
			file_hits++;
		end
	endfunction

	// advance the line state by one byte; returns 1 with the report on a line end
	function automatic bit scan_byte(input logic [7:0] b, input bit eol, input bit restart,
		output line_report_t rep);
		int unsigned len;
		bit hit;
		logic [7:0] p;
		logic [7:0] t;
		len = active_len();
		rep = '0;
		if (restart) begin
			clear_line_state();
			line_no = 1;
			file_hits = '0;
		end
		for (int k = WIN_BYTES - 1; k > 0; k--) begin
			win_bytes[k] = win_bytes[k - 1];
		end
		win_bytes[0] = b;
		if (seen_in_line < WIN_BYTES) begin
			seen_in_line++;
		end
		// a whole-word hit from the previous byte needs a separator now
		if (word_pending) begin
			if (is_separator(b)) begin
				bump_counts();
			end
			word_pending = 1'b0;
		end
		if (seen_in_line >= len) begin
			hit = 1'b1;
			for (int k = 0; k < len; k++) begin
				p = pat_byte(k);
				t = win_bytes[len - 1 - k];
				if (cur_mode != MODE_EXACT) begin
					p = lower_byte(p);
					t = lower_byte(t);
				end
				if (p != t) begin
					hit = 1'b0;
				end
			end
			if (hit) begin
				if (cur_mode == MODE_EXACT || cur_mode == MODE_FOLD) begin
					bump_counts();
				end else if (seen_in_line == len || is_separator(win_bytes[len])) begin
					if (eol) begin
						bump_counts();
					end else begin
						word_pending = 1'b1;
					end
				end
			end
		end
		if (eol) begin
			rep.line_number = line_no;
			rep.line_matches = line_hits;
			rep.file_total = file_hits;
			rep.has_match = (line_hits != 0);
			if (line_no != '1) begin
				line_no++;
			end
			clear_line_state();
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// ---------------------------------------------------------------- text generators

	function automatic logic [7:0] pick_separator();
		case ($urandom_range(5))
			0: begin
				return 8'h20;
			end
			1: begin
				return 8'h2C;
			end
			2: begin
				return 8'h00;
			end
			3: begin
				return 8'hFF;
			end
			4: begin
				return 8'h2E;
			end
			default: begin
				return 8'($urandom_range(47));
			end
		endcase
	endfunction

	function automatic logic [7:0] pick_alnum();
		case ($urandom_range(7))
			0: begin
				return "a";
			end
			1: begin
				return "b";
			end
			2: begin
				return "A";
			end
			3: begin
				return "B";
			end
			4: begin
				return "z";
			end
			5: begin
				return "Z";
			end
			6: begin
				return "0";
			end
			default: begin
				return "9";
			end
		endcase
	endfunction

	// flip the case of letters now and then when the mode folds case
	function automatic logic [7:0] vary_case(input logic [7:0] b);
		logic [7:0] l;
		l = b | 8'h20;
		if (cur_mode != MODE_EXACT && l >= 8'h61 && l <= 8'h7A && $urandom_range(1) == 1) begin
			return b ^ 8'h20;
		end
		return b;
	endfunction

	function automatic logic [7:0] pick_text();
		int r;
		r = $urandom_range(99);
		if (r < 40) begin
			return vary_case(pat_byte($urandom_range(active_len() - 1)));
		end
		if (r < 55) begin
			return pick_separator();
		end
		if (r < 75) begin
			return pick_alnum();
		end
		return 8'($urandom_range(255));
	endfunction

	// ---------------------------------------------------------------- table rows

	function automatic stim_row_t row_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] val);
		stim_row_t r;
		r = '0;
		r.kind = ROW_REG;
		r.reg_idx = idx;
		r.value = val;
		return r;
	endfunction

	function automatic stim_row_t row_txt(input logic [7:0] b, input bit eol, input bit restart);
		stim_row_t r;
		r = '0;
		r.kind = ROW_TEXT;
		r.text = b;
		r.eol = eol;
		r.restart = restart;
		return r;
	endfunction

	function automatic stim_row_t row_chk(input logic [7:0] b, input bit eol, input bit restart,
		input line_report_t want);
		stim_row_t r;
		r = row_txt(b, eol, restart);
		r.fixed = 1'b1;
		r.want = want;
		return r;
	endfunction

	// ---------------------------------------------------------------- bus tasks

	// offer one word, with a random gap first, and return once it is taken
	task automatic send_text(input logic [7:0] b, input bit eol, input bit restart);
		bit taken;
		if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			do begin
				@(posedge clk);
			end while ($urandom_range(99) < send_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= eol;
		s_tuser <= restart;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = s_tready;
			@(posedge clk);
		end
	endtask

	// caller lowers cfg_we after the last write of a group
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_PAT_WORD_0, REG_PAT_WORD_1, REG_PAT_WORD_2, REG_PAT_WORD_3: begin
				pat_words[idx[1:0]] = val;
			end
			REG_PAT_LEN: begin
				pat_len = val[LEN_CFG_W-1:0];
			end
			REG_MODE: begin
				cur_mode = val[MODE_W-1:0];
			end
			default: begin
			end
		endcase
		@(posedge clk);
	endtask

	// stop sending and wait for every due report, then let the pipeline empty
	task automatic drain_reports();
		s_tvalid <= 1'b0;
		while (reports_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic note_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		errors++;
		if (errors <= PRINT_LIMIT) begin
			$display("report %0d: %s got %0d expected %0d", reports_seen, what, got, want);
		end
	endtask

	// ---------------------------------------------------------------- report side

	// ready pattern, with a long hold-off on request
	always @(posedge clk) begin
		if (hold_req) begin
			hold_req = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// compare each taken report word with the oldest one due
	always @(negedge clk) begin : check_reports
		line_report_t want;
		if (arst_n && m_tvalid === 1'b1 && m_tready) begin
			if (reports_due.size() == 0) begin
				note_mismatch("report with none due, line_number", m_tdata[LINE_NUM_W-1:0],
					32'd0);
			end else begin
				want = reports_due.pop_front();
				if (m_tdata[LINE_NUM_W-1:0] !== want.line_number) begin
					note_mismatch("line_number", m_tdata[LINE_NUM_W-1:0], want.line_number);
				end
				if (m_tdata[LINE_NUM_W +: LINE_MATCH_W] !== want.line_matches) begin
					note_mismatch("line_matches", 32'(m_tdata[LINE_NUM_W +: LINE_MATCH_W]),
						32'(want.line_matches));
				end
				if (m_tdata[LINE_NUM_W + LINE_MATCH_W +: FILE_TOTAL_W] !== want.file_total) begin
					note_mismatch("file_total", m_tdata[LINE_NUM_W + LINE_MATCH_W +: FILE_TOTAL_W],
						want.file_total);
				end
				if (m_tuser !== want.has_match) begin
					note_mismatch("line_has_match", 32'(m_tuser), 32'(want.has_match));
				end
			end
			reports_seen++;
		end
	end

	// ---------------------------------------------------------------- stimulus

	initial begin : stimulus
		line_report_t rep;
		logic [7:0] chunk [$];
		logic [7:0] b;
		logic [PAT_WORD_W-1:0] words [PAT_WORDS];
		logic [LEN_CFG_W-1:0] len_raw;
		int sent;
		int r;
		bit eol;
		bit restart;

		// state after reset
		foreach (pat_words[k]) begin
			pat_words[k] = '0;
		end
		pat_len = LEN_CFG_W'(1);
		cur_mode = MODE_EXACT;
		clear_line_state();
		line_no = 1;
		file_hits = '0;

		plan = '{
			// reset pattern is a single nul byte
			row_chk(8'h00, 1'b1, 1'b0, line_report_t'{32'd1, 16'd1, 32'd1, 1'b1}),
			row_chk(8'hFF, 1'b1, 1'b0, line_report_t'{32'd2, 16'd0, 32'd1, 1'b0}),
			// "aB" case-folded, two hits in one line
			row_reg(REG_PAT_WORD_0, 64'h0000_0000_0000_4261),
			row_reg(REG_PAT_LEN, 64'd2),
			row_reg(REG_MODE, 64'(MODE_FOLD)),
			row_txt("x", 1'b0, 1'b0), row_txt("A", 1'b0, 1'b0), row_txt("b", 1'b0, 1'b0),
			row_txt("a", 1'b0, 1'b0), row_txt("B", 1'b1, 1'b0),
			// exact compare
			row_reg(REG_MODE, 64'(MODE_EXACT)),
			row_txt("a", 1'b0, 1'b0), row_txt("B", 1'b1, 1'b0),
			// whole word: letter before fails, hit on the line end byte is confirmed
			row_reg(REG_MODE, 64'(MODE_WORD)),
			row_txt("x", 1'b0, 1'b0), row_txt("a", 1'b0, 1'b0), row_txt("b", 1'b0, 1'b0),
			row_txt(",", 1'b0, 1'b0), row_txt("a", 1'b0, 1'b0), row_txt("B", 1'b1, 1'b0),
			// spare mode: pending confirmed by nul, pending dropped by a letter
			row_reg(REG_MODE, 64'(MODE_SPARE)),
			row_txt("a", 1'b0, 1'b0), row_txt("b", 1'b0, 1'b0), row_txt(8'h00, 1'b0, 1'b0),
			row_txt("a", 1'b0, 1'b0), row_txt("b", 1'b0, 1'b0), row_txt("c", 1'b1, 1'b0),
			// zero length acts as one, file restart on a line end byte
			row_reg(REG_PAT_WORD_0, 64'hFFFF_FFFF_FFFF_FFFF),
			row_reg(REG_PAT_LEN, 64'd0),
			row_reg(REG_MODE, 64'(MODE_EXACT)),
			row_chk(8'hFF, 1'b1, 1'b1, line_report_t'{32'd1, 16'd1, 32'd1, 1'b1}),
			// oversize length, restart drops the unfinished line
			row_reg(REG_PAT_WORD_1, 64'h5A5A_0F0F_C3C3_9669),
			row_reg(REG_PAT_WORD_2, 64'h0),
			row_reg(REG_PAT_WORD_3, 64'h8000_0000_0000_0001),
			row_reg(REG_PAT_LEN, 64'd63),
			row_txt("z", 1'b0, 1'b0),
			row_chk("q", 1'b1, 1'b1, line_report_t'{32'd1, 16'd0, 32'd0, 1'b0})
		};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed table
		for (int i = 0; i < plan.size(); i++) begin
			if (plan[i].kind == ROW_REG) begin
				if (i == 0 || plan[i - 1].kind != ROW_REG) begin
					drain_reports();
				end
				write_reg(plan[i].reg_idx, plan[i].value);
				if (i + 1 >= plan.size() || plan[i + 1].kind != ROW_REG) begin
					cfg_we <= 1'b0;
				end
			end else begin
				send_text(plan[i].text, plan[i].eol, plan[i].restart);
				if (scan_byte(plan[i].text, plan[i].eol, plan[i].restart, rep)) begin
					reports_due.push_back(plan[i].fixed ? plan[i].want : rep);
				end
			end
		end

		// random phases, each with its own pattern, mode and idling
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase % 4)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 83;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 83;
				end
				default: begin
					send_idle_pct = 24;
					recv_stall_pct = 24;
				end
			endcase

			// pattern mostly from a small alphabet so that hits overlap
			for (int k = 0; k < PAT_WORDS * 8; k++) begin
				r = $urandom_range(99);
				if (r < 70) begin
					b = pick_alnum();
				end else if (r < 85) begin
					b = pick_separator();
				end else begin
					b = 8'($urandom_range(255));
				end
				words[k / 8][(k % 8) * 8 +: 8] = b;
			end
			r = $urandom_range(99);
			if (r < 55) begin
				len_raw = LEN_CFG_W'($urandom_range(4, 1));
			end else if (r < 80) begin
				len_raw = LEN_CFG_W'($urandom_range(12, 5));
			end else if (r < 90) begin
				len_raw = LEN_CFG_W'(MAX_PATTERN_DEF);
			end else if (r < 95) begin
				len_raw = '0;
			end else begin
				len_raw = LEN_CFG_W'($urandom_range(63, 33));
			end

			drain_reports();
			write_reg(REG_PAT_WORD_0, words[0]);
			write_reg(REG_PAT_WORD_1, words[1]);
			write_reg(REG_PAT_WORD_2, words[2]);
			write_reg(REG_PAT_WORD_3, words[3]);
			write_reg(REG_PAT_LEN, 64'(len_raw));
			write_reg(REG_MODE, 64'((phase + phase / 4) % 4));
			cfg_we <= 1'b0;

			// receiver holds off while the sender keeps pushing, so the block backs up
			if (phase == 4) begin
				hold_req = 1'b1;
			end

			sent = 0;
			while (sent < ITEMS_PER_PHASE) begin
				chunk.delete();
				if ($urandom_range(99) < 40) begin
					// a copy of the pattern, sometimes spoilt, sometimes fenced by separators
					if ($urandom_range(1) == 1) begin
						chunk.push_back(pick_separator());
					end
					for (int k = 0; k < active_len(); k++) begin
						chunk.push_back(vary_case(pat_byte(k)));
					end
					if ($urandom_range(99) < 15) begin
						chunk[$urandom_range(chunk.size() - 1)] = 8'($urandom_range(255));
					end
					if ($urandom_range(1) == 1) begin
						chunk.push_back(pick_separator());
					end
				end else begin
					chunk.push_back(pick_text());
				end
				foreach (chunk[k]) begin
					eol = ($urandom_range(99) < 7) ||
						(k == chunk.size() - 1 && $urandom_range(99) < 15);
					restart = ($urandom_range(199) == 0);
					send_text(chunk[k], eol, restart);
					if (scan_byte(chunk[k], eol, restart, rep)) begin
						reports_due.push_back(rep);
					end
					sent++;
				end
			end
		end

		// wind down
		drain_reports();
		repeat (SETTLE * 2) @(posedge clk);
		if (errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
